>>> src/rv64i_decode_with_label_alloc_macros.svh
// Assertion macros used by the checker file.
`ifndef RV64I_DECODE_WITH_LABEL_ALLOC_MACROS_SVH
`define RV64I_DECODE_WITH_LABEL_ALLOC_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RDLA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdla assertion failed");

// Next-cycle implication, disabled in reset.
`define RDLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdla assertion failed");

`endif

>>> src/rdla_pkg.sv
// Package: opcodes, mnemonic codes and result layout of the RV64I decoder.
`timescale 1ns / 1ps
package rdla_pkg;

  localparam int MAX_LINES_DEF = 1024;

  localparam int INSTR_W = 32;
  localparam int MN_W    = 6;
  localparam int REG_W   = 5;
  localparam int IMM_W   = 21;
  localparam int LBL_W   = 11;
  localparam int CNT_W   = 11;
  localparam int OUT_W   = 64;

  // result layout in m_tdata, lowest bit first
  localparam int MN_LO   = 0;
  localparam int RD_LO   = MN_LO + MN_W;
  localparam int RS1_LO  = RD_LO + REG_W;
  localparam int RS2_LO  = RS1_LO + REG_W;
  localparam int IMM_LO  = RS2_LO + REG_W;
  localparam int TLBL_LO = IMM_LO + IMM_W;
  localparam int LLBL_LO = TLBL_LO + LBL_W;

  localparam logic [6:0] OP_R      = 7'd51;
  localparam logic [6:0] OP_IMM    = 7'd19;
  localparam logic [6:0] OP_LOAD   = 7'd3;
  localparam logic [6:0] OP_JALR   = 7'd103;
  localparam logic [6:0] OP_STORE  = 7'd35;
  localparam logic [6:0] OP_BRANCH = 7'd99;
  localparam logic [6:0] OP_JAL    = 7'd111;
  localparam logic [6:0] OP_LUI    = 7'd55;

  localparam logic [6:0] F7_ALT = 7'd32;

  localparam logic [MN_W-1:0] MN_ADD     = 6'd0;
  localparam logic [MN_W-1:0] MN_SUB     = 6'd1;
  localparam logic [MN_W-1:0] MN_SLL     = 6'd2;
  localparam logic [MN_W-1:0] MN_SLT     = 6'd3;
  localparam logic [MN_W-1:0] MN_SLTU    = 6'd4;
  localparam logic [MN_W-1:0] MN_XOR     = 6'd5;
  localparam logic [MN_W-1:0] MN_SRL     = 6'd6;
  localparam logic [MN_W-1:0] MN_SRA     = 6'd7;
  localparam logic [MN_W-1:0] MN_OR      = 6'd8;
  localparam logic [MN_W-1:0] MN_AND     = 6'd9;
  localparam logic [MN_W-1:0] MN_ADDI    = 6'd10;
  localparam logic [MN_W-1:0] MN_SLLI    = 6'd11;
  localparam logic [MN_W-1:0] MN_SLTI    = 6'd12;
  localparam logic [MN_W-1:0] MN_SLTIU   = 6'd13;
  localparam logic [MN_W-1:0] MN_XORI    = 6'd14;
  localparam logic [MN_W-1:0] MN_SRLI    = 6'd15;
  localparam logic [MN_W-1:0] MN_SRAI    = 6'd16;
  localparam logic [MN_W-1:0] MN_ORI     = 6'd17;
  localparam logic [MN_W-1:0] MN_ANDI    = 6'd18;
  localparam logic [MN_W-1:0] MN_LB      = 6'd19;
  localparam logic [MN_W-1:0] MN_JALR    = 6'd26;
  localparam logic [MN_W-1:0] MN_SB      = 6'd27;
  localparam logic [MN_W-1:0] MN_BEQ     = 6'd31;
  localparam logic [MN_W-1:0] MN_BLT     = 6'd33;
  localparam logic [MN_W-1:0] MN_JAL     = 6'd37;
  localparam logic [MN_W-1:0] MN_LUI     = 6'd38;
  localparam logic [MN_W-1:0] MN_INVALID = 6'd39;

endpackage

>>> src/rv64i_decode_with_label_alloc.sv
// RV64I subset decoder with branch-target label allocation (top level).
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------
//   s_*      | in        | s_tvalid/s_tready  | s_tdata: instr_word
//   m_*      | out       | m_tvalid/m_tready  | m_tdata: decode result, m_tuser: flag
//   cfg_*    | in        | cfg_valid/cfg_ready| cfg_data: line_count
//
// One instruction per cycle when not clearing or stalled; results pass s1, then m_tdata.
// The label table is one memory, read at the target and current line and written
// at most once per item; a write in the same cycle as the next read is forwarded.
// After reset a clearing pass zeroes every table entry while s_tready is held low.
// A stalled output holds the pipeline; one request more is taken while the output waits.
`timescale 1ns / 1ps
module rv64i_decode_with_label_alloc #(
  parameter int MAX_LINES = rdla_pkg::MAX_LINES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rdla_pkg::INSTR_W-1:0] s_tdata,   // instr_word
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // mnemonic, dest_reg, src1_reg, src2_reg, immediate, target_label, line_label
  output logic [rdla_pkg::OUT_W-1:0]   m_tdata,
  output logic                         m_tuser,   // target_is_label
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rdla_pkg::CNT_W-1:0]   cfg_data   // line_count
);

  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int LW    = $clog2(MAX_LINES + 2);
  localparam int TW    = ((IDX_W + 1 > rdla_pkg::IMM_W) ? IDX_W + 1 : rdla_pkg::IMM_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LINES - 1);
  localparam logic [TW-1:0]    MAX_TW   = TW'(MAX_LINES);

  typedef struct packed {
    logic [rdla_pkg::MN_W-1:0]         mn;
    logic [rdla_pkg::REG_W-1:0]        rd;
    logic [rdla_pkg::REG_W-1:0]        rs1;
    logic [rdla_pkg::REG_W-1:0]        rs2;
    logic signed [rdla_pkg::IMM_W-1:0] imm;
    logic                              tgt_ok;
    logic [IDX_W-1:0]                  tgt;
    logic [IDX_W-1:0]                  line;
  } stage_t;

  function automatic logic [rdla_pkg::LBL_W-1:0] lbl_out(input logic [LW-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[rdla_pkg::LBL_W-1:0];
  endfunction

  logic [LW-1:0] table_mem [MAX_LINES];

  logic [rdla_pkg::CNT_W-1:0] line_count;
  logic [IDX_W-1:0]           line_index;
  logic [LW-1:0]              next_label;
  logic                       clearing;
  logic [IDX_W-1:0]           clr_addr;

  logic          s1_valid;
  stage_t        s1;
  logic [LW-1:0] rd_t;
  logic [LW-1:0] rd_l;
  logic          fwd_t;
  logic          fwd_l;
  logic [LW-1:0] fwd_data;

  stage_t dec;
  logic   is_tgt;
  logic   in_fire;
  logic   s1_adv;

  logic [6:0]                        opc;
  logic [2:0]                        f3;
  logic [6:0]                        f7;
  logic signed [rdla_pkg::IMM_W-1:0] imm_i;
  logic signed [rdla_pkg::IMM_W-1:0] q;
  logic signed [TW-1:0]              tgt_s;
  logic [TW-1:0]                     lim;

  logic [LW-1:0] t_old;
  logic [LW-1:0] l_old;
  logic          alloc;
  logic [LW-1:0] tlab;
  logic [LW-1:0] llab;
  logic          wr_item;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign s1_adv    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !clearing && (!s1_valid || s1_adv);

  // decode
  always_comb begin
    opc    = s_tdata[6:0];
    f3     = s_tdata[14:12];
    f7     = s_tdata[31:25];
    imm_i  = rdla_pkg::IMM_W'($signed(s_tdata[31:20]));
    dec    = '0;
    dec.mn = rdla_pkg::MN_INVALID;
    is_tgt = 1'b0;
    unique case (opc)
      rdla_pkg::OP_R: begin
        case (f3)
          3'd0:    dec.mn = (f7 == rdla_pkg::F7_ALT) ? rdla_pkg::MN_SUB : rdla_pkg::MN_ADD;
          3'd1:    dec.mn = rdla_pkg::MN_SLL;
          3'd2:    dec.mn = rdla_pkg::MN_SLT;
          3'd3:    dec.mn = rdla_pkg::MN_SLTU;
          3'd4:    dec.mn = rdla_pkg::MN_XOR;
          3'd5:    dec.mn = (f7 == rdla_pkg::F7_ALT) ? rdla_pkg::MN_SRA : rdla_pkg::MN_SRL;
          3'd6:    dec.mn = rdla_pkg::MN_OR;
          default: dec.mn = rdla_pkg::MN_AND;
        endcase
        dec.rd  = s_tdata[11:7];
        dec.rs1 = s_tdata[19:15];
        dec.rs2 = s_tdata[24:20];
      end
      rdla_pkg::OP_IMM: begin
        dec.imm = imm_i;
        case (f3)
          3'd0:    dec.mn = rdla_pkg::MN_ADDI;
          3'd1: begin
            dec.mn  = rdla_pkg::MN_SLLI;
            dec.imm = rdla_pkg::IMM_W'(s_tdata[25:20]);
          end
          3'd2:    dec.mn = rdla_pkg::MN_SLTI;
          3'd3:    dec.mn = rdla_pkg::MN_SLTIU;
          3'd4:    dec.mn = rdla_pkg::MN_XORI;
          3'd5: begin
            dec.mn  = (s_tdata[31:26] != 6'd0) ? rdla_pkg::MN_SRAI : rdla_pkg::MN_SRLI;
            dec.imm = rdla_pkg::IMM_W'(s_tdata[25:20]);
          end
          3'd6:    dec.mn = rdla_pkg::MN_ORI;
          default: dec.mn = rdla_pkg::MN_ANDI;
        endcase
        dec.rd  = s_tdata[11:7];
        dec.rs1 = s_tdata[19:15];
      end
      rdla_pkg::OP_LOAD: begin
        if (f3 != 3'd7) begin
          dec.mn  = rdla_pkg::MN_LB + rdla_pkg::MN_W'(f3);
          dec.imm = imm_i;
          dec.rd  = s_tdata[11:7];
          dec.rs1 = s_tdata[19:15];
        end
      end
      rdla_pkg::OP_JALR: begin
        dec.mn  = rdla_pkg::MN_JALR;
        dec.imm = imm_i;
        dec.rd  = s_tdata[11:7];
        dec.rs1 = s_tdata[19:15];
      end
      rdla_pkg::OP_STORE: begin
        if (!f3[2]) begin
          dec.mn  = rdla_pkg::MN_SB + rdla_pkg::MN_W'(f3[1:0]);
          dec.imm = rdla_pkg::IMM_W'($signed({f7, s_tdata[11:7]}));
          dec.rs1 = s_tdata[19:15];
          dec.rs2 = s_tdata[24:20];
        end
      end
      rdla_pkg::OP_BRANCH: begin
        if (f3 != 3'd2 && f3 != 3'd3) begin
          dec.mn  = f3[2] ? rdla_pkg::MN_BLT + rdla_pkg::MN_W'(f3[1:0])
                          : rdla_pkg::MN_BEQ + rdla_pkg::MN_W'(f3[0]);
          dec.imm = rdla_pkg::IMM_W'($signed({s_tdata[31], s_tdata[7], s_tdata[30:25],
                                              s_tdata[11:8], 1'b0}));
          dec.rs1 = s_tdata[19:15];
          dec.rs2 = s_tdata[24:20];
          is_tgt  = 1'b1;
        end
      end
      rdla_pkg::OP_JAL: begin
        dec.mn  = rdla_pkg::MN_JAL;
        dec.imm = $signed({s_tdata[31], s_tdata[19:12], s_tdata[20], s_tdata[30:21], 1'b0});
        dec.rd  = s_tdata[11:7];
        is_tgt  = 1'b1;
      end
      rdla_pkg::OP_LUI: begin
        dec.mn  = rdla_pkg::MN_LUI;
        dec.imm = rdla_pkg::IMM_W'(s_tdata[31:12]);
        dec.rd  = s_tdata[11:7];
      end
      default: dec.mn = rdla_pkg::MN_INVALID;
    endcase

    // target line: offset / 4 rounded toward zero
    q          = $signed(dec.imm + (dec.imm[rdla_pkg::IMM_W-1] ? rdla_pkg::IMM_W'(3)
                                                                : rdla_pkg::IMM_W'(0))) >>> 2;
    tgt_s      = TW'($signed({1'b0, line_index})) + TW'(q);
    lim        = (TW'(line_count) > MAX_TW) ? MAX_TW : TW'(line_count);
    dec.tgt_ok = is_tgt && !tgt_s[TW-1] && (tgt_s[TW-2:0] < lim[TW-2:0]);
    dec.tgt    = tgt_s[IDX_W-1:0];
    dec.line   = line_index;
  end

  // label resolve
  always_comb begin
    t_old   = fwd_t ? fwd_data : rd_t;
    l_old   = fwd_l ? fwd_data : rd_l;
    alloc   = s1.tgt_ok && (t_old == '0);
    tlab    = !s1.tgt_ok ? '0 : (alloc ? next_label : t_old);
    llab    = (alloc && s1.tgt == s1.line) ? next_label : l_old;
    wr_item = s1_adv && alloc;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      table_mem[clr_addr] <= '0;
    end else if (wr_item) begin
      table_mem[s1.tgt] <= next_label;
    end
    if (in_fire) begin
      rd_t     <= table_mem[dec.tgt];
      rd_l     <= table_mem[dec.line];
      fwd_data <= next_label;
      s1       <= dec;
    end
    if (s1_adv) begin
      m_tdata <= {lbl_out(llab), lbl_out(tlab), s1.imm, s1.rs2, s1.rs1, s1.rd, s1.mn};
      m_tuser <= s1.tgt_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= rdla_pkg::CNT_W'(1);
      line_index <= '0;
      next_label <= LW'(1);
      clearing   <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
      fwd_t      <= 1'b0;
      fwd_l      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        line_count <= cfg_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + IDX_W'(1);
        if (clr_addr == LAST_IDX) begin
          clearing <= 1'b0;
        end
      end
      if (wr_item) begin
        next_label <= next_label + LW'(1);
      end
      if (in_fire) begin
        line_index <= (line_index == LAST_IDX) ? '0 : line_index + IDX_W'(1);
        fwd_t      <= wr_item && (s1.tgt == dec.tgt);
        fwd_l      <= wr_item && (s1.tgt == dec.line);
        s1_valid   <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> src/rdla_checker.sv
// Port checker for the RV64I decoder, bound to the top level.
`timescale 1ns / 1ps
`include "rv64i_decode_with_label_alloc_macros.svh"
module rdla_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [rdla_pkg::OUT_W-1:0]   m_tdata,
  input logic                         m_tuser
);

  logic [rdla_pkg::MN_W-1:0]  mn;
  logic [rdla_pkg::LBL_W-1:0] tlbl;
  logic                       zero_fields;

  assign mn          = m_tdata[rdla_pkg::MN_LO +: rdla_pkg::MN_W];
  assign tlbl        = m_tdata[rdla_pkg::TLBL_LO +: rdla_pkg::LBL_W];
  assign zero_fields = (m_tdata[rdla_pkg::TLBL_LO-1:rdla_pkg::RD_LO] == '0) && !m_tuser;

  `RDLA_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `RDLA_ASSERT_NOW(a_flag, clk, rst, m_tvalid, m_tuser == (tlbl != '0))
  `RDLA_ASSERT_NOW(a_inv, clk, rst, m_tvalid && mn == rdla_pkg::MN_INVALID, zero_fields)
  `RDLA_ASSERT_NOW(a_clr, clk, rst, $past(rst), !s_tready && !m_tvalid)

endmodule

bind rv64i_decode_with_label_alloc rdla_checker u_rdla_checker (.*);
